// ===== hdl/triangle_plane_clipper_macros.svh =====
// assertion macros shared by the clipper checker
`ifndef TRIANGLE_PLANE_CLIPPER_MACROS_SVH
`define TRIANGLE_PLANE_CLIPPER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TPC_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: label");

// next-cycle implication, sampled on clk, off during reset
`define TPC_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: label");

`endif

// ===== hdl/tpc_pkg.sv =====
// types, constants and codes for the triangle plane clipper
`timescale 1ns / 1ps

package tpc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int T_BITS = 24;
    localparam int NUM_FIELDS = 5;
    localparam int CFG_ADDR_WIDTH = 3;

    // configuration register indexes
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_NORMAL_X = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_NORMAL_Y = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_NORMAL_Z = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_POINT_X  = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_POINT_Y  = 3'd4;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_POINT_Z  = 3'd5;

    localparam logic signed [COORD_WIDTH-1:0] NORMAL_Z_RESET = 32'sd65536;
    localparam logic signed [COORD_WIDTH-1:0] POINT_Z_RESET  = 32'sd6554;

    // source of an emitted vertex
    localparam logic [2:0] SRC_V0 = 3'd0;
    localparam logic [2:0] SRC_V1 = 3'd1;
    localparam logic [2:0] SRC_V2 = 3'd2;
    localparam logic [2:0] SRC_C0 = 3'd3;
    localparam logic [2:0] SRC_C1 = 3'd4;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] in_x;
        logic signed [COORD_WIDTH-1:0] in_y;
        logic signed [COORD_WIDTH-1:0] in_z;
        logic signed [COORD_WIDTH-1:0] in_u;
        logic signed [COORD_WIDTH-1:0] in_v;
    } in_beat_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic signed [COORD_WIDTH-1:0] out_u;
        logic signed [COORD_WIDTH-1:0] out_v;
        logic                          tri_index;
        logic [1:0]                    corner;
        logic                          last;
    } out_beat_t;

    // x,y,z,u,v with x in slot 0
    typedef logic [NUM_FIELDS-1:0][COORD_WIDTH-1:0] coord_vec_t;

    typedef struct packed {
        logic [2:0] src;
        logic       tri_index;
        logic [1:0] corner;
        logic       last;
    } plan_item_t;

endpackage

// ===== hdl/triangle_plane_clipper.sv =====
// clips one triangle against a configured plane with a shared multiplier and divider
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------
//  in      | in_valid / in_stall    | in_data   (one vertex)
//  out     | out_valid / out_stall  | out_data  (one vertex)
//  cfg     | cfg_valid / cfg_ready  | cfg_addr, cfg_wdata
//
// the first two vertices of a triangle are only stored; the third starts the clip:
// distances by multiply/accumulate, classify, then per cut a divide setup, a restoring
// divide and a multiply/round per field, then one beat per cycle while the output does
// not stall: no beats with nothing inside, one triangle with one or all inside, two with two
// reset clears the vertex count and loads the default plane, no clearing pass
// in_stall is high from the third vertex until the last beat enters the output register,
// or until classification with none inside; a stalled output beat holds the emit walk
`timescale 1ns / 1ps

module triangle_plane_clipper
    import tpc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_beat_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_beat_t                 out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [COORD_WIDTH-1:0]    cfg_wdata
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * CW + 2;
    localparam int SW = 2 * CW + 3;
    localparam int DW = SW - FRAC_BITS;
    localparam int RW = DW + 2;
    localparam int STW = $clog2(T_BITS);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_ACC  = 9'b000000100,
        S_PLAN = 9'b000001000,
        S_DSET = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_IMUL = 9'b001000000,
        S_IACC = 9'b010000000,
        S_EMIT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [CW-1:0] normal_reg [3];
    logic signed [CW-1:0] point_reg [3];
    logic [1:0]           count_reg;
    coord_vec_t           vert_reg [3];
    coord_vec_t           cut_reg [2];
    logic signed [DW-1:0] dist_reg [3];
    logic signed [SW-1:0] acc_reg;
    logic signed [PW-1:0] prod_reg;
    logic [1:0]           vi_reg;
    logic [1:0]           ax_reg;
    logic [1:0]           ci_reg [2];
    logic [1:0]           co_reg [2];
    logic                 cut_sel_reg;
    coord_vec_t           wi_reg;
    coord_vec_t           wo_reg;
    logic [RW-1:0]        den_reg;
    logic [RW-1:0]        rem_reg;
    logic [T_BITS-1:0]    quo_reg;
    logic [STW-1:0]       step_reg;
    logic [2:0]           fld_reg;
    plan_item_t           plan_reg [6];
    logic [2:0]           emit_reg;
    logic [2:0]           emit_last_reg;
    logic                 out_valid_reg;
    out_beat_t            out_reg;

    logic                 in_acc;
    logic signed [CW:0]   op_a;
    logic signed [CW:0]   op_b;
    logic signed [PW-1:0] prod_next;
    logic signed [SW-1:0] acc_next;
    logic [2:0]           inside_mask;
    logic [RW-1:0]        rem_shift;
    logic signed [PW-1:0] rnd_sum;
    logic signed [PW-1:0] rnd_shift;
    logic                 load_ok;
    plan_item_t           cur_item;
    coord_vec_t           cur_vec;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    for (genvar i = 0; i < 3; i++) begin : g_inside
        assign inside_mask[i] = !dist_reg[i][DW-1];
    end

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            S_MUL:
            begin
                op_a = $signed({vert_reg[vi_reg][ax_reg][CW-1], vert_reg[vi_reg][ax_reg]})
                     - $signed({point_reg[ax_reg][CW-1], point_reg[ax_reg]});
                op_b = $signed({normal_reg[ax_reg][CW-1], normal_reg[ax_reg]});
            end
            default:
            begin
                op_a = $signed({wo_reg[fld_reg][CW-1], wo_reg[fld_reg]})
                     - $signed({wi_reg[fld_reg][CW-1], wi_reg[fld_reg]});
                op_b = $signed({{(CW + 1 - T_BITS){1'b0}}, quo_reg});
            end
        endcase
    end

    assign prod_next = PW'(op_a) * PW'(op_b);
    assign acc_next  = acc_reg + SW'(prod_reg);
    assign rem_shift = {rem_reg[RW-2:0], 1'b0};
    assign rnd_sum   = prod_reg + (PW'(1) <<< (T_BITS - 1));
    assign rnd_shift = rnd_sum >>> T_BITS;

    assign load_ok  = !out_valid_reg || !out_stall;
    assign cur_item = plan_reg[emit_reg];

    always_comb
    begin
        case (cur_item.src)
            SRC_V0:  cur_vec = vert_reg[0];
            SRC_V1:  cur_vec = vert_reg[1];
            SRC_V2:  cur_vec = vert_reg[2];
            SRC_C0:  cur_vec = cut_reg[0];
            SRC_C1:  cur_vec = cut_reg[1];
            default: cur_vec = vert_reg[0];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_acc && count_reg == 2'd2)
                    state_next = S_MUL;
            S_MUL:
                state_next = S_ACC;
            S_ACC:
                if (ax_reg == 2'd2 && vi_reg == 2'd2)
                    state_next = S_PLAN;
                else
                    state_next = S_MUL;
            S_PLAN:
                case (inside_mask)
                    3'b000:  state_next = S_IDLE;
                    3'b111:  state_next = S_EMIT;
                    default: state_next = S_DSET;
                endcase
            S_DSET:
                state_next = S_DIV;
            S_DIV:
                if (step_reg == STW'(T_BITS - 1))
                    state_next = S_IMUL;
            S_IMUL:
                state_next = S_IACC;
            S_IACC:
                if (fld_reg == 3'(NUM_FIELDS - 1))
                    state_next = cut_sel_reg ? S_EMIT : S_DSET;
                else
                    state_next = S_IMUL;
            S_EMIT:
                if (load_ok && emit_reg == emit_last_reg)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
            normal_reg[0] <= '0;
            normal_reg[1] <= '0;
            normal_reg[2] <= NORMAL_Z_RESET;
            point_reg[0]  <= '0;
            point_reg[1]  <= '0;
            point_reg[2]  <= POINT_Z_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
                count_reg <= (count_reg == 2'd2) ? 2'd0 : count_reg + 2'd1;
            if (state_reg == S_EMIT && load_ok)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_addr)
                    REG_NORMAL_X: normal_reg[0] <= cfg_wdata;
                    REG_NORMAL_Y: normal_reg[1] <= cfg_wdata;
                    REG_NORMAL_Z: normal_reg[2] <= cfg_wdata;
                    REG_POINT_X:  point_reg[0]  <= cfg_wdata;
                    REG_POINT_Y:  point_reg[1]  <= cfg_wdata;
                    REG_POINT_Z:  point_reg[2]  <= cfg_wdata;
                    default:      ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (state_reg)
            S_IDLE:
                if (in_acc)
                begin
                    vert_reg[count_reg] <= {in_data.in_v, in_data.in_u, in_data.in_z,
                                            in_data.in_y, in_data.in_x};
                    vi_reg  <= 2'd0;
                    ax_reg  <= 2'd0;
                    acc_reg <= '0;
                end
            S_ACC:
                if (ax_reg == 2'd2)
                begin
                    dist_reg[vi_reg] <= DW'(acc_next >>> FRAC_BITS);
                    acc_reg <= '0;
                    ax_reg  <= 2'd0;
                    vi_reg  <= vi_reg + 2'd1;
                end
                else
                begin
                    acc_reg <= acc_next;
                    ax_reg  <= ax_reg + 2'd1;
                end
            S_PLAN:
            begin
                cut_sel_reg   <= 1'b0;
                emit_reg      <= 3'd0;
                case (inside_mask)
                    // one vertex inside: it, then cuts toward the two outside ones
                    3'b001, 3'b010, 3'b100:
                    begin
                        emit_last_reg <= 3'd2;
                        case (inside_mask)
                            3'b001:
                            begin
                                ci_reg[0] <= 2'd0; co_reg[0] <= 2'd1;
                                ci_reg[1] <= 2'd0; co_reg[1] <= 2'd2;
                                plan_reg[0] <= '{SRC_V0, 1'b0, 2'd0, 1'b0};
                            end
                            3'b010:
                            begin
                                ci_reg[0] <= 2'd1; co_reg[0] <= 2'd0;
                                ci_reg[1] <= 2'd1; co_reg[1] <= 2'd2;
                                plan_reg[0] <= '{SRC_V1, 1'b0, 2'd0, 1'b0};
                            end
                            default:
                            begin
                                ci_reg[0] <= 2'd2; co_reg[0] <= 2'd0;
                                ci_reg[1] <= 2'd2; co_reg[1] <= 2'd1;
                                plan_reg[0] <= '{SRC_V2, 1'b0, 2'd0, 1'b0};
                            end
                        endcase
                        plan_reg[1] <= '{SRC_C0, 1'b0, 2'd1, 1'b0};
                        plan_reg[2] <= '{SRC_C1, 1'b0, 2'd2, 1'b1};
                    end
                    // two inside: quad split into two triangles
                    3'b011, 3'b101, 3'b110:
                    begin
                        emit_last_reg <= 3'd5;
                        case (inside_mask)
                            3'b011:
                            begin
                                ci_reg[0] <= 2'd0; co_reg[0] <= 2'd2;
                                ci_reg[1] <= 2'd1; co_reg[1] <= 2'd2;
                                plan_reg[0] <= '{SRC_V0, 1'b0, 2'd0, 1'b0};
                                plan_reg[1] <= '{SRC_V1, 1'b0, 2'd1, 1'b0};
                                plan_reg[3] <= '{SRC_V1, 1'b1, 2'd0, 1'b0};
                            end
                            3'b101:
                            begin
                                ci_reg[0] <= 2'd0; co_reg[0] <= 2'd1;
                                ci_reg[1] <= 2'd2; co_reg[1] <= 2'd1;
                                plan_reg[0] <= '{SRC_V0, 1'b0, 2'd0, 1'b0};
                                plan_reg[1] <= '{SRC_V2, 1'b0, 2'd1, 1'b0};
                                plan_reg[3] <= '{SRC_V2, 1'b1, 2'd0, 1'b0};
                            end
                            default:
                            begin
                                ci_reg[0] <= 2'd1; co_reg[0] <= 2'd0;
                                ci_reg[1] <= 2'd2; co_reg[1] <= 2'd0;
                                plan_reg[0] <= '{SRC_V1, 1'b0, 2'd0, 1'b0};
                                plan_reg[1] <= '{SRC_V2, 1'b0, 2'd1, 1'b0};
                                plan_reg[3] <= '{SRC_V2, 1'b1, 2'd0, 1'b0};
                            end
                        endcase
                        plan_reg[2] <= '{SRC_C0, 1'b0, 2'd2, 1'b0};
                        plan_reg[4] <= '{SRC_C0, 1'b1, 2'd1, 1'b0};
                        plan_reg[5] <= '{SRC_C1, 1'b1, 2'd2, 1'b1};
                    end
                    default:
                    begin
                        emit_last_reg <= 3'd2;
                        plan_reg[0] <= '{SRC_V0, 1'b0, 2'd0, 1'b0};
                        plan_reg[1] <= '{SRC_V1, 1'b0, 2'd1, 1'b0};
                        plan_reg[2] <= '{SRC_V2, 1'b0, 2'd2, 1'b1};
                    end
                endcase
            end
            S_DSET:
            begin
                wi_reg   <= vert_reg[ci_reg[cut_sel_reg]];
                wo_reg   <= vert_reg[co_reg[cut_sel_reg]];
                den_reg  <= RW'($signed(dist_reg[ci_reg[cut_sel_reg]]))
                          - RW'($signed(dist_reg[co_reg[cut_sel_reg]]));
                rem_reg  <= RW'($signed(dist_reg[ci_reg[cut_sel_reg]]));
                quo_reg  <= '0;
                step_reg <= '0;
                fld_reg  <= 3'd0;
            end
            S_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (rem_shift >= den_reg)
                begin
                    rem_reg <= rem_shift - den_reg;
                    quo_reg <= {quo_reg[T_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[T_BITS-2:0], 1'b0};
                end
                step_reg <= step_reg + STW'(1);
            end
            S_IACC:
            begin
                cut_reg[cut_sel_reg][fld_reg] <= wi_reg[fld_reg] + rnd_shift[CW-1:0];
                if (fld_reg == 3'(NUM_FIELDS - 1))
                    cut_sel_reg <= 1'b1;
                else
                    fld_reg <= fld_reg + 3'd1;
            end
            S_EMIT:
                if (load_ok)
                begin
                    out_reg.out_x     <= cur_vec[0];
                    out_reg.out_y     <= cur_vec[1];
                    out_reg.out_z     <= cur_vec[2];
                    out_reg.out_u     <= cur_vec[3];
                    out_reg.out_v     <= cur_vec[4];
                    out_reg.tri_index <= cur_item.tri_index;
                    out_reg.corner    <= cur_item.corner;
                    out_reg.last      <= cur_item.last;
                    emit_reg          <= emit_reg + 3'd1;
                end
            default:
                ;
        endcase
    end

endmodule

// ===== hdl/tpc_checker.sv =====
// port-level checks for the triangle plane clipper, bound to the top level
`timescale 1ns / 1ps
`include "triangle_plane_clipper_macros.svh"

module tpc_checker
    import tpc_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input out_beat_t                 out_data,
    input logic                      cfg_valid,
    input logic                      cfg_ready
);

    // a stalled result beat stays up and unchanged
    `TPC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // a stalled vertex beat stays offered
    `TPC_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid)

    // corner code three never leaves the block
    `TPC_ASSERT_IMP(a_corner_range, out_valid, out_data.corner != 2'd3)

    // the closing beat of a triangle is always its third corner
    `TPC_ASSERT_IMP(a_last_corner, out_valid && out_data.last, out_data.corner == 2'd2)

    // register writes are never refused
    `TPC_ASSERT_IMP(a_cfg_taken, cfg_valid, cfg_ready)

endmodule

bind triangle_plane_clipper tpc_checker u_tpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
